@@ rtl/core/ssag_pkg.sv @@
// Package for the strided slice address generator.
// Holds field widths, register indexes, reset values and parameter defaults.
// No dependencies.
`default_nettype none

package ssag_pkg;

  // Parameter defaults
  localparam int unsigned MaxDimsDefault  = 4;
  localparam int unsigned AddrBitsDefault = 32;

  // Fixed field widths
  localparam int unsigned ElemBits     = 64;
  localparam int unsigned OutAddrBits  = 32;
  localparam int unsigned FieldBits    = 16;
  localparam int unsigned StrideBits   = 32;
  localparam int unsigned PosBits      = FieldBits + 1;
  localparam int unsigned ProdBits     = PosBits + StrideBits;
  localparam int unsigned RegDimFields = 4;
  localparam int unsigned DimsBits     = 3;
  localparam int unsigned DimsCalcBits = 4;

  // Configuration port
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 64;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgDimsInUse     = 3'd0,
    CfgExtents       = 3'd1,
    CfgStarts        = 3'd2,
    CfgStridesOuter  = 3'd3,
    CfgStridesInner  = 3'd4
  } cfg_index_e;

  // Register reset values
  localparam logic [DimsBits-1:0]    DimsReset    = 3'd1;
  localparam logic [CfgDataBits-1:0] ExtentsReset = 64'h0001_0001_0001_0001;
  localparam logic [CfgDataBits-1:0] StartsReset  = 64'h0;
  localparam logic [CfgDataBits-1:0] StridesReset = 64'h0;

endpackage

`default_nettype wire

@@ rtl/core/strided_slice_address_generator.sv @@
// Strided slice address generator: odometer over slice indices plus a
// three-stage offset / multiply / sum pipeline. Depends on ssag_pkg.
`default_nettype none

// Takes one element per transfer in slice order and returns it with its source
// tensor offset, the sum over used dimensions of (index + start) * stride,
// modulo 2^ADDR_BITS and shown on 32 bits, and a last flag on the final element
// of the slice, after which the indices wrap to zero. One item is accepted
// every clock while results are taken; a stalled output fills the three stages
// and then holds the input. Each result passes through the three pipeline
// registers, the first of which the input transfer itself loads: offset add
// with the odometer step, one multiplier per dimension, then the adder over all
// dimensions. Configuration writes take effect for the next accepted element
// and leave the indices as they are; write only while the pipeline is empty.
module strided_slice_address_generator #(
  parameter int unsigned MAX_DIMS  = ssag_pkg::MaxDimsDefault,
  parameter int unsigned ADDR_BITS = ssag_pkg::AddrBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [ssag_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  wire logic [ssag_pkg::CfgDataBits-1:0]   cfg_data_i,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [ssag_pkg::ElemBits-1:0]      element_in_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [ssag_pkg::OutAddrBits-1:0]        source_address_o,
  output logic [ssag_pkg::ElemBits-1:0]           element_out_o,
  output logic                                    slice_last_o
);

  localparam int unsigned FB = ssag_pkg::FieldBits;
  localparam int unsigned SB = ssag_pkg::StrideBits;
  localparam int unsigned PB = ssag_pkg::PosBits;
  localparam int unsigned MB = ssag_pkg::ProdBits;
  localparam int unsigned EB = ssag_pkg::ElemBits;
  localparam int unsigned NB = ssag_pkg::DimsCalcBits;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ssag_pkg::DimsBits-1:0]    dims_q;
  logic [ssag_pkg::CfgDataBits-1:0] extents_q;
  logic [ssag_pkg::CfgDataBits-1:0] starts_q;
  logic [ssag_pkg::CfgDataBits-1:0] strides_outer_q;
  logic [ssag_pkg::CfgDataBits-1:0] strides_inner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q          <= ssag_pkg::DimsReset;
      extents_q       <= ssag_pkg::ExtentsReset;
      starts_q        <= ssag_pkg::StartsReset;
      strides_outer_q <= ssag_pkg::StridesReset;
      strides_inner_q <= ssag_pkg::StridesReset;
    end else if (cfg_we_i) begin
      case (ssag_pkg::cfg_index_e'(cfg_index_i))
        ssag_pkg::CfgDimsInUse:    dims_q <= cfg_data_i[ssag_pkg::DimsBits-1:0];
        ssag_pkg::CfgExtents:      extents_q <= cfg_data_i;
        ssag_pkg::CfgStarts:       starts_q <= cfg_data_i;
        ssag_pkg::CfgStridesOuter: strides_outer_q <= cfg_data_i;
        ssag_pkg::CfgStridesInner: strides_inner_q <= cfg_data_i;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Per-dimension view of the registers; dimensions past the fields are fixed
  logic [FB-1:0] ext_w    [MAX_DIMS];
  logic [FB-1:0] start_w  [MAX_DIMS];
  logic [SB-1:0] stride_w [MAX_DIMS];

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim_cfg
    if (d < ssag_pkg::RegDimFields) begin : g_reg
      assign ext_w[d]   = extents_q[FB*d +: FB];
      assign start_w[d] = starts_q[FB*d +: FB];
      if (d < 2) begin : g_outer
        assign stride_w[d] = strides_outer_q[SB*d +: SB];
      end else begin : g_inner
        assign stride_w[d] = strides_inner_q[SB*(d-2) +: SB];
      end
    end else begin : g_fixed
      assign ext_w[d]    = FB'(1);
      assign start_w[d]  = '0;
      assign stride_w[d] = '0;
    end
  end

  // Used dimension count: zero acts as one, capped at MAX_DIMS
  logic [NB-1:0] dims_used;
  always_comb begin
    dims_used = NB'(dims_q);
    if (dims_used == '0) begin
      dims_used = NB'(1);
    end
    if (dims_used > NB'(MAX_DIMS)) begin
      dims_used = NB'(MAX_DIMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q;
  logic rdy0, rdy1, rdy2;
  logic in_xfer;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Odometer
  // ---------------------------------------------------------------------------
  logic [FB-1:0] cnt_q [MAX_DIMS];
  logic [FB-1:0] cnt_d [MAX_DIMS];
  logic          last_d;

  always_comb begin
    logic          carry;
    logic [PB-1:0] nxt;
    carry = 1'b1;
    nxt   = '0;
    for (int k = MAX_DIMS - 1; k >= 0; k--) begin
      nxt = PB'(cnt_q[k]) + PB'(1);
      if (k >= int'(dims_used)) begin
        cnt_d[k] = '0;
      end else if (carry) begin
        // a zero extent wraps as an extent of one does
        if (nxt >= PB'(ext_w[k])) begin
          cnt_d[k] = '0;
        end else begin
          cnt_d[k] = nxt[FB-1:0];
          carry    = 1'b0;
        end
      end else begin
        cnt_d[k] = cnt_q[k];
      end
    end
    last_d = carry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (in_xfer) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: source positions
  // ---------------------------------------------------------------------------
  logic [PB-1:0] pos_q [MAX_DIMS];
  logic [EB-1:0] elem0_q;
  logic          last0_q;

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        // unused dimensions contribute nothing
        if (k < int'(dims_used)) begin
          pos_q[k] <= PB'(cnt_q[k]) + PB'(start_w[k]);
        end else begin
          pos_q[k] <= '0;
        end
      end
      elem0_q <= element_in_i;
      last0_q <= last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: one product per dimension
  // ---------------------------------------------------------------------------
  logic [ADDR_BITS-1:0] prod_q [MAX_DIMS];
  logic [EB-1:0]        elem1_q;
  logic                 last1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        prod_q[k] <= ADDR_BITS'(MB'(pos_q[k]) * MB'(stride_w[k]));
      end
      elem1_q <= elem0_q;
      last1_q <= last0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sum into the result register
  // ---------------------------------------------------------------------------
  logic [ADDR_BITS-1:0] addr_sum;
  logic [ADDR_BITS-1:0] addr_q;
  logic [EB-1:0]        elem2_q;
  logic                 last2_q;

  always_comb begin
    addr_sum = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      addr_sum = addr_sum + prod_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      addr_q  <= addr_sum;
      elem2_q <= elem1_q;
      last2_q <= last1_q;
    end
  end

  assign out_valid_o      = v2_q;
  assign source_address_o = ssag_pkg::OutAddrBits'(addr_q);
  assign element_out_o    = elem2_q;
  assign slice_last_o     = last2_q;

`ifndef SYNTHESIS
  logic cnt_all_zero;
  always_comb begin
    cnt_all_zero = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (cnt_q[k] != '0) cnt_all_zero = 1'b0;
    end
  end

  // the odometer wraps to zero after the final element of the slice
  a_wrap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_d) |=> cnt_all_zero)
    else $error("odometer not cleared after final element");

  // an empty result register never holds back the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while result register empty");

  // a transfer into a full pipeline needs the output to move
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && v0_q && v1_q && v2_q) |-> out_ready_i)
    else $error("input taken while pipeline full and stalled");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for strided_slice_address_generator: directed table, then random
// register settings with element streams, checked against an odometer model. Uses ssag_pkg.

module tb_top;

  localparam int CfgIdxBits    = ssag_pkg::CfgIdxBits;
  localparam int CfgDataBits   = ssag_pkg::CfgDataBits;
  localparam int OutAddrBits   = ssag_pkg::OutAddrBits;
  localparam int ElemBits      = ssag_pkg::ElemBits;
  localparam int DimsBits      = ssag_pkg::DimsBits;
  localparam int FieldBits     = ssag_pkg::FieldBits;
  localparam int RegDimFields  = ssag_pkg::RegDimFields;

  localparam int ClkPeriod     = 10;
  localparam int PipeDepth     = 3;
  localparam int NumDims       = ssag_pkg::MaxDimsDefault;
  localparam int RandomItems   = 1280;
  localparam int CalmTail      = 180;
  localparam int HoldOffPhase  = 3;
  localparam int HoldOffCycles = 300;
  localparam int CycleLimit    = 200000;

  // indexes past the register list; writes to them must be dropped
  localparam logic [CfgIdxBits-1:0] CfgSpareFirst = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgSpareLast  = 3'd7;

  typedef enum logic {RowCfg, RowElem} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CfgIdxBits-1:0]    idx;
    logic [CfgDataBits-1:0]   data;
    logic                     typed;
    logic [OutAddrBits-1:0]   addr;
    logic                     last;
  } plan_row_t;

  typedef struct {
    logic [OutAddrBits-1:0] addr;
    logic [ElemBits-1:0]    elem;
    logic                   last;
  } slice_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [ElemBits-1:0]    element_in_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [OutAddrBits-1:0] source_address_o;
  logic [ElemBits-1:0]    element_out_o;
  logic                   slice_last_o;

  strided_slice_address_generator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .element_in_i     (element_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .source_address_o (source_address_o),
    .element_out_o    (element_out_o),
    .slice_last_o     (slice_last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // odometer model: register copies and per-dimension indices
  logic [DimsBits-1:0]    dims_reg = ssag_pkg::DimsReset;
  logic [CfgDataBits-1:0] extents_reg = ssag_pkg::ExtentsReset;
  logic [CfgDataBits-1:0] starts_reg = ssag_pkg::StartsReset;
  logic [CfgDataBits-1:0] strides_outer_reg = ssag_pkg::StridesReset;
  logic [CfgDataBits-1:0] strides_inner_reg = ssag_pkg::StridesReset;
  logic [FieldBits-1:0]   odometer [NumDims] = '{default: '0};

  slice_result_t pending_results [$];
  plan_row_t     directed_plan [$];

  logic                   typed_on = 1'b0;
  logic [OutAddrBits-1:0] typed_addr = '0;
  logic                   typed_last = 1'b0;
  logic                   send_idle_on = 1'b1;
  logic                   recv_idle_on = 1'b1;
  logic                   hold_off_req = 1'b0;

  int elements_accepted = 0;
  int slices_closed = 0;
  int mismatches = 0;
  int settings_written = 0;
  int cycle_count = 0;

  // Source offset of the current index set, then advance the odometer.
  function automatic void step_odometer(output logic [OutAddrBits-1:0] addr,
                                        output logic last);
    int unsigned used;
    logic [31:0] pos;
    logic [31:0] stride;
    logic [16:0] nxt;
    logic [16:0] ext;
    used = (dims_reg == 0) ? 1 : (dims_reg > NumDims) ? NumDims : dims_reg;
    addr = '0;
    for (int d = 0; d < used; d++) begin
      pos = 32'(odometer[d]) + 32'(starts_reg[16*d +: 16]);
      if (d < 2) stride = strides_outer_reg[32*d +: 32];
      else stride = strides_inner_reg[32*(d-2) +: 32];
      addr += pos * stride;
    end
    last = 1'b1;
    for (int k = int'(used) - 1; k >= 0; k--) begin
      ext = 17'(extents_reg[16*k +: 16]);
      if (ext == 0) ext = 17'd1;
      nxt = 17'(odometer[k]) + 17'd1;
      // an index at or past its extent wraps just as one reaching it
      if (nxt >= ext) begin
        odometer[k] = '0;
      end else begin
        odometer[k] = nxt[FieldBits-1:0];
        last = 1'b0;
        break;
      end
    end
    for (int d = used; d < NumDims; d++) odometer[d] = '0;
  endfunction

  // Track register writes and transfers on both channels.
  always @(posedge clk_i) begin
    slice_result_t want;
    slice_result_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ssag_pkg::CfgDimsInUse:    dims_reg = cfg_data_i[DimsBits-1:0];
          ssag_pkg::CfgExtents:      extents_reg = cfg_data_i;
          ssag_pkg::CfgStarts:       starts_reg = cfg_data_i;
          ssag_pkg::CfgStridesOuter: strides_outer_reg = cfg_data_i;
          ssag_pkg::CfgStridesInner: strides_inner_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        step_odometer(want.addr, want.last);
        if (typed_on) begin
          want.addr = typed_addr;
          want.last = typed_last;
        end
        want.elem = element_in_i;
        pending_results.push_back(want);
        elements_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: source_address %h", source_address_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          got.addr = source_address_o;
          got.elem = element_out_o;
          got.last = slice_last_o;
          if (got.addr !== want.addr) begin
            $error("source_address: expected %h, actual %h", want.addr, got.addr);
            mismatches++;
          end
          if (got.elem !== want.elem) begin
            $error("element_out: expected %h, actual %h", want.elem, got.elem);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("slice_last: expected %b, actual %b", want.last, got.last);
            mismatches++;
          end
          if (got.last === 1'b1) slices_closed++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        out_ready_i = 1'b1;
        hold_off_req = 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic add_cfg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] value);
    plan_row_t r;
    r.kind = RowCfg;
    r.idx = idx;
    r.data = value;
    r.typed = 1'b0;
    r.addr = '0;
    r.last = 1'b0;
    directed_plan.push_back(r);
  endtask

  task automatic add_elem(input logic [ElemBits-1:0] value, input logic typed,
                          input logic [OutAddrBits-1:0] addr, input logic last);
    plan_row_t r;
    r.kind = RowElem;
    r.idx = '0;
    r.data = value;
    r.typed = typed;
    r.addr = addr;
    r.last = last;
    directed_plan.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_element(input logic [ElemBits-1:0] value);
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    element_in_i = value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (PipeDepth) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] value);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic pick_setting(input int phase);
    logic [DimsBits-1:0]    dims;
    logic [CfgDataBits-1:0] ext;
    logic [CfgDataBits-1:0] sta;
    logic [CfgDataBits-1:0] str_o;
    logic [CfgDataBits-1:0] str_i;
    if (phase == 0) begin
      dims = '0;
      ext = '0;
      sta = '0;
      str_o = '0;
      str_i = '0;
    end else if (phase == 1) begin
      dims = '1;
      ext = '1;
      sta = '1;
      str_o = '1;
      str_i = '1;
    end else begin
      dims = DimsBits'($urandom_range(0, 7));
      for (int d = 0; d < RegDimFields; d++) begin
        // mostly short extents so that slices close often
        ext[16*d +: 16] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 4));
        sta[16*d +: 16] = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 3));
      end
      for (int h = 0; h < 2; h++) begin
        str_o[32*h +: 32] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 64);
        str_i[32*h +: 32] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 64);
      end
    end
    if ($urandom_range(0, 2) == 0)
      write_reg(CfgIdxBits'($urandom_range(CfgSpareFirst, CfgSpareLast)), {$urandom, $urandom});
    write_reg(ssag_pkg::CfgDimsInUse, {{(CfgDataBits-DimsBits){1'b0}}, dims});
    write_reg(ssag_pkg::CfgExtents, ext);
    write_reg(ssag_pkg::CfgStarts, sta);
    write_reg(ssag_pkg::CfgStridesOuter, str_o);
    write_reg(ssag_pkg::CfgStridesInner, str_i);
    settings_written++;
  endtask

  initial begin
    int random_sent;
    int phase;
    int burst;

    // after reset every extent is one, so each element closes a slice at offset 0
    add_elem(64'h0, 1'b1, 32'h0, 1'b1);
    add_elem(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0, 1'b1);
    // two dimensions, extents 2 x 3, starts 1 / 2, strides 100 / 1
    add_cfg(ssag_pkg::CfgDimsInUse, 64'h2);
    add_cfg(ssag_pkg::CfgExtents, 64'h0001_0001_0003_0002);
    add_cfg(ssag_pkg::CfgStarts, 64'h0000_0000_0002_0001);
    add_cfg(ssag_pkg::CfgStridesOuter, 64'h0000_0001_0000_0064);
    add_elem(64'h5555_5555_5555_5555, 1'b1, 32'h66, 1'b0);
    add_elem(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 32'h67, 1'b0);
    add_elem(64'h8000_0000_0000_0001, 1'b0, '0, 1'b0);
    add_elem(64'h0123_4567_89AB_CDEF, 1'b0, '0, 1'b0);
    add_elem(64'hFEDC_BA98_7654_3210, 1'b0, '0, 1'b0);
    add_elem(64'h1, 1'b1, 32'hCC, 1'b1);
    // dimension count capped, zero extents act as one, all-ones starts and strides
    add_cfg(ssag_pkg::CfgDimsInUse, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(ssag_pkg::CfgExtents, 64'h0);
    add_cfg(ssag_pkg::CfgStarts, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(ssag_pkg::CfgStridesOuter, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(ssag_pkg::CfgStridesInner, 64'hFFFF_FFFF_FFFF_FFFF);
    add_elem(64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 32'hFFFC_0004, 1'b1);
    add_elem(64'h0, 1'b1, 32'hFFFC_0004, 1'b1);
    // zero dimension count acts as one; extent 3, stride 16
    add_cfg(ssag_pkg::CfgDimsInUse, 64'h8);
    add_cfg(ssag_pkg::CfgExtents, 64'h3);
    add_cfg(ssag_pkg::CfgStarts, 64'h0);
    add_cfg(ssag_pkg::CfgStridesOuter, 64'h10);
    add_elem(64'hDEAD_BEEF_0000_0001, 1'b1, 32'h0, 1'b0);
    add_elem(64'hDEAD_BEEF_0000_0002, 1'b1, 32'h10, 1'b0);
    add_elem(64'hDEAD_BEEF_0000_0003, 1'b1, 32'h20, 1'b1);
    add_cfg(CfgSpareFirst, 64'hFFFF_FFFF_FFFF_FFFF);
    add_elem(64'hC0DE_0000_0000_0004, 1'b1, 32'h0, 1'b0);
    // widen the extent, walk the index up to 5, then shrink the extent below it
    add_cfg(ssag_pkg::CfgExtents, 64'h8);
    add_elem(64'h1111_1111_1111_1111, 1'b0, '0, 1'b0);
    add_elem(64'h2222_2222_2222_2222, 1'b0, '0, 1'b0);
    add_elem(64'h3333_3333_3333_3333, 1'b0, '0, 1'b0);
    add_elem(64'h4444_4444_4444_4444, 1'b0, '0, 1'b0);
    add_cfg(ssag_pkg::CfgExtents, 64'h2);
    add_elem(64'h9999_9999_9999_9999, 1'b1, 32'h50, 1'b1);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == RowCfg) begin
        drain_pipeline();
        write_reg(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        typed_on = directed_plan[i].typed;
        typed_addr = directed_plan[i].addr;
        typed_last = directed_plan[i].last;
        send_element(directed_plan[i].data);
      end
    end
    typed_on = 1'b0;

    random_sent = 0;
    phase = 0;
    while (random_sent < RandomItems) begin
      drain_pipeline();
      pick_setting(phase);
      // every fifth setting runs without gaps on either side
      send_idle_on = (phase % 5 != 4);
      recv_idle_on = (phase % 5 != 4);
      if (phase == HoldOffPhase) hold_off_req = 1'b1;
      burst = (phase == HoldOffPhase) ? 200 : $urandom_range(30, 90);
      repeat (burst) begin
        if (random_sent >= RandomItems - CalmTail) begin
          send_idle_on = 1'b0;
          recv_idle_on = 1'b0;
        end
        send_element({$urandom, $urandom});
        random_sent++;
      end
      phase++;
    end

    drain_pipeline();
    repeat (PipeDepth * 4) @(negedge clk_i);

    $display("Run covered %0d elements (%0d directed rows) over %0d random register settings,",
             elements_accepted, directed_plan.size(), settings_written);
    $display("with %0d slice ends seen and %0d mismatches.", slices_closed, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ strided_slice_address_generator.f @@
rtl/core/ssag_pkg.sv
rtl/core/strided_slice_address_generator.sv
verif/tb_top.sv
